// ===== design/pit3_pkg.sv =====
// Package for the 3D point-in-triangle block: defaults, widths and register indexes.
`default_nettype none
package pit3_pkg;
  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned TOL_BITS       = 32;
  localparam int unsigned CFG_IDX_BITS   = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BARY_TOL     = 2'd0,
    CFG_COPLANAR_TOL = 2'd1
  } cfg_idx_e;
endpackage
`default_nettype wire

// ===== design/point_in_triangle_3d.sv =====
// Top level: pipelined exact barycentric point-in-triangle test in three dimensions.
// Throughput one item per cycle while the output is not stalled.
// Seven register stages: differences, coordinate products, dot and cross sums,
// split partial products, product assembly, determinant and numerators, compare.
// A stalled output freezes the whole pipeline; in_ready_o follows the last stage.
// Reset (rst_ni low, asynchronous) clears all valid bits and both tolerances to 0.
`default_nettype none
module point_in_triangle_3d
  import pit3_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // config write channel
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  wire  [TOL_BITS-1:0]          cfg_data_i,
  // input items
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  signed [COORD_BITS-1:0] point_x_i,
  input  wire  signed [COORD_BITS-1:0] point_y_i,
  input  wire  signed [COORD_BITS-1:0] point_z_i,
  input  wire  signed [COORD_BITS-1:0] vert_a_x_i,
  input  wire  signed [COORD_BITS-1:0] vert_a_y_i,
  input  wire  signed [COORD_BITS-1:0] vert_a_z_i,
  input  wire  signed [COORD_BITS-1:0] vert_b_x_i,
  input  wire  signed [COORD_BITS-1:0] vert_b_y_i,
  input  wire  signed [COORD_BITS-1:0] vert_b_z_i,
  input  wire  signed [COORD_BITS-1:0] vert_c_x_i,
  input  wire  signed [COORD_BITS-1:0] vert_c_y_i,
  input  wire  signed [COORD_BITS-1:0] vert_c_z_i,
  // result items
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic                         inside_res_o,
  output logic                         coplanar_o,
  output logic                         degenerate_o
);
  localparam int unsigned D    = COORD_BITS + 1;      // difference width
  localparam int unsigned PW   = 2 * D;               // coordinate product
  localparam int unsigned DW   = 2 * D + 2;           // dot product
  localparam int unsigned CW   = 2 * D + 1;           // cross term
  localparam int unsigned H    = (DW + 1) / 2;        // dot split, low part
  localparam int unsigned DH   = DW - H;              // dot split, high part
  localparam int unsigned CH   = (CW + 1) / 2;        // cross split, low part
  localparam int unsigned CHH  = CW - CH;             // cross split, high part
  localparam int unsigned FW   = 2 * DW;              // dot times dot
  localparam int unsigned TW   = D + CW;              // determinant term
  localparam int unsigned NW   = FW + 1;              // den, nu, nv
  localparam int unsigned DETW = TW + 2;
  localparam int unsigned EW   = 4 * D + 48;          // compare width
  localparam int unsigned NST  = 7;

  // Tolerance registers
  logic [TOL_BITS-1:0] bary_tol_q, coplanar_tol_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bary_tol_q     <= '0;
      coplanar_tol_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BARY_TOL:     bary_tol_q     <= cfg_data_i;
        CFG_COPLANAR_TOL: coplanar_tol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: whole pipe advances unless the output item is held
  logic           en;
  logic [NST-1:0] v_q;
  assign en          = !v_q[NST-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], in_valid_i};
    end
  end

  // Stage 1: difference vectors
  logic signed [COORD_BITS-1:0] p [3], a [3], b [3], c [3];
  assign p = '{point_x_i, point_y_i, point_z_i};
  assign a = '{vert_a_x_i, vert_a_y_i, vert_a_z_i};
  assign b = '{vert_b_x_i, vert_b_y_i, vert_b_z_i};
  assign c = '{vert_c_x_i, vert_c_y_i, vert_c_z_i};

  logic signed [D-1:0] ra_q [3], rb_q [3], rc_q [3], e0_q [3], e1_q [3], e2_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ra_q[k] <= D'(a[k]) - D'(p[k]);
        rb_q[k] <= D'(b[k]) - D'(p[k]);
        rc_q[k] <= D'(c[k]) - D'(p[k]);
        e0_q[k] <= D'(c[k]) - D'(a[k]);
        e1_q[k] <= D'(b[k]) - D'(a[k]);
        e2_q[k] <= D'(p[k]) - D'(a[k]);
      end
    end
  end

  // Stage 2: coordinate products (cross minors and dot components)
  logic signed [PW-1:0] bc_q [6];
  logic signed [PW-1:0] dp_q [5][3];
  logic signed [D-1:0]  ra2_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      bc_q[0] <= rb_q[1] * rc_q[2];
      bc_q[1] <= rb_q[2] * rc_q[1];
      bc_q[2] <= rb_q[0] * rc_q[2];
      bc_q[3] <= rb_q[2] * rc_q[0];
      bc_q[4] <= rb_q[0] * rc_q[1];
      bc_q[5] <= rb_q[1] * rc_q[0];
      for (int k = 0; k < 3; k++) begin
        dp_q[0][k] <= e0_q[k] * e0_q[k];
        dp_q[1][k] <= e0_q[k] * e1_q[k];
        dp_q[2][k] <= e0_q[k] * e2_q[k];
        dp_q[3][k] <= e1_q[k] * e1_q[k];
        dp_q[4][k] <= e1_q[k] * e2_q[k];
        ra2_q[k]   <= ra_q[k];
      end
    end
  end

  // Stage 3: cross terms and dot products (d00 d01 d02 d11 d12)
  logic signed [CW-1:0] cr_q [3];
  logic signed [DW-1:0] dot_q [5];
  logic signed [D-1:0]  ra3_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      cr_q[0] <= CW'(bc_q[0]) - CW'(bc_q[1]);
      cr_q[1] <= CW'(bc_q[2]) - CW'(bc_q[3]);
      cr_q[2] <= CW'(bc_q[4]) - CW'(bc_q[5]);
      for (int j = 0; j < 5; j++) begin
        dot_q[j] <= DW'(dp_q[j][0]) + DW'(dp_q[j][1]) + DW'(dp_q[j][2]);
      end
      ra3_q <= ra2_q;
    end
  end

  // Stage 4: split partial products
  // operand pairs: d00*d11, d01*d01, d11*d02, d01*d12, d00*d12, d01*d02
  logic signed [DW-1:0] opx [6], opy [6];
  assign opx = '{dot_q[0], dot_q[1], dot_q[3], dot_q[1], dot_q[0], dot_q[1]};
  assign opy = '{dot_q[3], dot_q[1], dot_q[2], dot_q[4], dot_q[4], dot_q[2]};

  logic signed [2*DH-1:0]   hh_q [6];
  logic signed [DH+H:0]     hl_q [6], lh_q [6];
  logic signed [2*H+1:0]    ll_q [6];
  logic signed [D+CHH-1:0]  dh_q [3];
  logic signed [D+CH:0]     dl_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        hh_q[j] <= $signed(opx[j][DW-1:H]) * $signed(opy[j][DW-1:H]);
        hl_q[j] <= $signed(opx[j][DW-1:H]) * $signed({1'b0, opy[j][H-1:0]});
        lh_q[j] <= $signed({1'b0, opx[j][H-1:0]}) * $signed(opy[j][DW-1:H]);
        ll_q[j] <= $signed({1'b0, opx[j][H-1:0]}) * $signed({1'b0, opy[j][H-1:0]});
      end
      for (int k = 0; k < 3; k++) begin
        dh_q[k] <= ra3_q[k] * $signed(cr_q[k][CW-1:CH]);
        dl_q[k] <= ra3_q[k] * $signed({1'b0, cr_q[k][CH-1:0]});
      end
    end
  end

  // Stage 5: assemble full products
  logic signed [FW-1:0] fp_q [6];
  logic signed [TW-1:0] dt_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        fp_q[j] <= (FW'(hh_q[j]) <<< (2 * H)) + ((FW'(hl_q[j]) + FW'(lh_q[j])) <<< H)
                 + FW'(ll_q[j]);
      end
      for (int k = 0; k < 3; k++) begin
        dt_q[k] <= (TW'(dh_q[k]) <<< CH) + TW'(dl_q[k]);
      end
    end
  end

  // Stage 6: denominator, numerators, determinant
  logic signed [NW-1:0]   den_q, nu_q, nv_q;
  logic signed [DETW-1:0] det_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q <= NW'(fp_q[0]) - NW'(fp_q[1]);
      nu_q  <= NW'(fp_q[2]) - NW'(fp_q[3]);
      nv_q  <= NW'(fp_q[4]) - NW'(fp_q[5]);
      det_q <= DETW'(dt_q[0]) - DETW'(dt_q[1]) + DETW'(dt_q[2]);
    end
  end

  // Stage 7: tolerance compares and flags
  logic signed [EW-1:0] den_e, nu_e, nv_e, det_e, adet_e, t_e, ct_e, hi_e;
  logic                 cop, deg, ok;
  always_comb begin
    den_e  = EW'(den_q);
    nu_e   = EW'(nu_q);
    nv_e   = EW'(nv_q);
    det_e  = EW'(det_q);
    adet_e = det_e[EW-1] ? -det_e : det_e;
    t_e    = $signed(EW'(bary_tol_q));
    ct_e   = $signed(EW'(coplanar_tol_q));
    hi_e   = den_e + t_e;
    cop    = adet_e <= ct_e;
    deg    = den_q == '0;
    ok     = (nu_e >= -t_e) && (nu_e <= hi_e) && (nv_e >= -t_e) && (nv_e <= hi_e)
          && ((nu_e + nv_e) <= hi_e);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inside_res_o <= cop && !deg && ok;
      coplanar_o   <= cop;
      degenerate_o <= deg;
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for point_in_triangle_3d: exact barycentric inside/coplanar/degenerate checks.
`timescale 1ns / 1ps
module tb_top;
  import pit3_pkg::*;

  localparam int CB = 24;
  localparam int LATENCY = 7;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct {
    coord_t p[3];
    coord_t a[3];
    coord_t b[3];
    coord_t c[3];
  } tri_query_t;
  typedef struct {
    logic in_tri;
    logic cop;
    logic deg;
  } tri_verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [TOL_BITS-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  coord_t point_x_i = '0, point_y_i = '0, point_z_i = '0;
  coord_t vert_a_x_i = '0, vert_a_y_i = '0, vert_a_z_i = '0;
  coord_t vert_b_x_i = '0, vert_b_y_i = '0, vert_b_z_i = '0;
  coord_t vert_c_x_i = '0, vert_c_y_i = '0, vert_c_z_i = '0;
  wire cfg_ready_o, in_ready_o, out_valid_o, inside_res_o, coplanar_o, degenerate_o;

  point_in_triangle_3d uut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor copy of the tolerance registers
  logic [31:0] slack_tol;
  logic [31:0] plane_tol;
  tri_verdict_t verdict_q[$];
  int mismatches;
  int quiet_phase;
  longint cycles;

  // Exact predictor; 160-bit signed holds every intermediate
  function automatic tri_verdict_t classify(tri_query_t q);
    logic signed [159:0] ap[3], bp[3], cp[3], e0[3], e1[3], e2[3];
    logic signed [159:0] det, d00, d01, d02, d11, d12, den, nu, nv, t, hi;
    tri_verdict_t v;
    for (int k = 0; k < 3; k++) begin
      ap[k] = 160'(q.a[k]) - 160'(q.p[k]);
      bp[k] = 160'(q.b[k]) - 160'(q.p[k]);
      cp[k] = 160'(q.c[k]) - 160'(q.p[k]);
      e0[k] = 160'(q.c[k]) - 160'(q.a[k]);
      e1[k] = 160'(q.b[k]) - 160'(q.a[k]);
      e2[k] = 160'(q.p[k]) - 160'(q.a[k]);
    end
    det = ap[0] * (bp[1] * cp[2] - bp[2] * cp[1])
        - ap[1] * (bp[0] * cp[2] - bp[2] * cp[0])
        + ap[2] * (bp[0] * cp[1] - bp[1] * cp[0]);
    if (det < 0) det = -det;
    d00 = e0[0] * e0[0] + e0[1] * e0[1] + e0[2] * e0[2];
    d01 = e0[0] * e1[0] + e0[1] * e1[1] + e0[2] * e1[2];
    d02 = e0[0] * e2[0] + e0[1] * e2[1] + e0[2] * e2[2];
    d11 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
    d12 = e1[0] * e2[0] + e1[1] * e2[1] + e1[2] * e2[2];
    den = d00 * d11 - d01 * d01;
    nu = d11 * d02 - d01 * d12;
    nv = d00 * d12 - d01 * d02;
    t = 160'($unsigned(slack_tol));
    hi = den + t;
    v.cop = det <= 160'($unsigned(plane_tol));
    v.deg = den == 0;
    v.in_tri = v.cop && !v.deg && (nu >= -t) && (nu <= hi) && (nv >= -t) && (nv <= hi)
             && (nu + nv <= hi);
    return v;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(3) == 0) return 0;
    return ($urandom_range(19) == 0) ? $urandom_range(40, 10) : $urandom_range(3);
  endfunction

  // valid stays up between back-to-back items; it drops only for a gap or a drain
  task automatic send_query(tri_query_t q);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {point_x_i, point_y_i, point_z_i} <= {q.p[0], q.p[1], q.p[2]};
    {vert_a_x_i, vert_a_y_i, vert_a_z_i} <= {q.a[0], q.a[1], q.a[2]};
    {vert_b_x_i, vert_b_y_i, vert_b_z_i} <= {q.b[0], q.b[1], q.b[2]};
    {vert_c_x_i, vert_c_y_i, vert_c_z_i} <= {q.c[0], q.c[1], q.c[2]};
    do @(posedge clk_i); while (!in_ready_o);
    verdict_q.push_back(classify(q));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_BARY_TOL) slack_tol = val;
    else plane_tol = val;
  endtask

  task automatic set_tols(logic [31:0] bt, logic [31:0] ct);
    drain();
    write_reg(CFG_BARY_TOL, bt);
    write_reg(CFG_COPLANAR_TOL, ct);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic coord_t rnd_coord(int span);
    case ($urandom_range(5))
      0: return coord_t'($urandom);
      1: return $urandom_range(1) ? coord_t'(24'h7FFFFF) : coord_t'(24'h800000);
      default: return coord_t'($signed($urandom_range(2 * span)) - span);
    endcase
  endfunction

  // Triangle with P built as an integer barycentric mix so it often lands inside
  function automatic tri_query_t planar_query(int span);
    tri_query_t q;
    int w0, w1;
    for (int k = 0; k < 3; k++) begin
      q.a[k] = coord_t'($signed($urandom_range(2 * span)) - span);
      q.b[k] = coord_t'($signed($urandom_range(2 * span)) - span);
      q.c[k] = coord_t'($signed($urandom_range(2 * span)) - span);
    end
    w0 = $urandom_range(4);
    w1 = $urandom_range(4 - w0);
    for (int k = 0; k < 3; k++)
      q.p[k] = coord_t'((int'(q.a[k]) * (4 - w0 - w1) + int'(q.b[k]) * w0
                         + int'(q.c[k]) * w1) / 4);
    if ($urandom_range(4) == 0) q.p[$urandom_range(2)] += coord_t'($urandom_range(3) - 1);
    return q;
  endfunction

  function automatic tri_query_t rand_query(int span);
    tri_query_t q;
    for (int k = 0; k < 3; k++) begin
      q.p[k] = rnd_coord(span);
      q.a[k] = rnd_coord(span);
      q.b[k] = rnd_coord(span);
      q.c[k] = rnd_coord(span);
    end
    return q;
  endfunction

  function automatic tri_query_t mk(int px, int py, int pz, int ax, int ay, int az,
                                    int bx, int by, int bz, int cx, int cy, int cz);
    tri_query_t q;
    q.p = '{coord_t'(px), coord_t'(py), coord_t'(pz)};
    q.a = '{coord_t'(ax), coord_t'(ay), coord_t'(az)};
    q.b = '{coord_t'(bx), coord_t'(by), coord_t'(bz)};
    q.c = '{coord_t'(cx), coord_t'(cy), coord_t'(cz)};
    return q;
  endfunction

  // Directed: interior, vertex, edge, outside, off-plane, degenerate, extremes
  task automatic test_directed();
    localparam int ONE = 65536;
    localparam int MX = 8388607;
    localparam int MN = -8388608;
    send_query(mk(ONE/4, ONE/4, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_query(mk(0, 0, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_query(mk(ONE, 0, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_query(mk(ONE/2, ONE/2, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_query(mk(ONE/2, 0, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_query(mk(ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_query(mk(-1, 0, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_query(mk(ONE/4, ONE/4, 1, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_query(mk(5, 5, 5, 0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE));
    send_query(mk(3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3));
    send_query(mk(MX, MX, MX, MN, MN, MN, MX, MN, MN, MN, MX, MN));
    send_query(mk(MN, MN, MN, MX, MX, MX, MN, MX, MX, MX, MN, MX));
    send_query(mk(MN, MN, 0, MN, MN, 0, MX, MN, 0, MN, MX, 0));
    send_query(mk(MX, MX, MX, MX, MX, MX, MN, MN, MN, MN, MX, 0));
    send_query(mk(-1, -1, -1, 0, 0, 0, -1, -1, 0, 0, 0, -1));
    send_query(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int count, int span);
    for (int i = 0; i < count; i++)
      send_query(($urandom_range(9) < 6) ? planar_query(span) : rand_query(span));
  endtask

  // Results, with random backpressure outside the quiet phase
  always @(posedge clk_i) begin
    tri_verdict_t want;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item at cycle %0d", cycles);
        end else begin
          want = verdict_q.pop_front();
          if ({inside_res_o, coplanar_o, degenerate_o} !== {want.in_tri, want.cop, want.deg})
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: inside/cop/deg exp %b%b%b got %b%b%b", want.in_tri,
                       want.cop, want.deg, inside_res_o, coplanar_o, degenerate_o);
          end
        end
      end
      out_ready_i <= quiet_phase ? 1'b1 : ($urandom_range(9) != 0) ||
                     ($urandom_range(30) == 0 && out_ready_i);
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    quiet_phase = 0;
    slack_tol = 0;
    plane_tol = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(400, 64);
    // pause the sender until all results are in
    drain();
    set_tols(32'd1000, 32'd5000);
    test_directed();
    test_random(300, 1 << 20);
    set_tols(32'hFFFFFFFF, 32'hFFFFFFFF);
    test_directed();
    test_random(300, 1000);
    set_tols($urandom, $urandom);
    test_random(300, 1 << 23);
    quiet_phase = 1;
    set_tols(32'd0, 32'd0);
    test_random(400, 256);
    drain();
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

// ===== point_in_triangle_3d.f =====
design/pit3_pkg.sv
design/point_in_triangle_3d.sv
tb/tb_top.sv
